FILE: src/gss_pkg.sv
// shared constants and types for the six-track gate step sequencer
package gss_pkg;

	localparam int TRACKS = 6;
	localparam int STEPS = 8;
	localparam int TRACK_W = 3;
	localparam int STEP_W = 3;

	// play mode codes
	localparam logic [1:0] MODE_DEFAULT = 2'd0;
	localparam logic [1:0] MODE_DIVIDE = 2'd1;
	localparam logic [1:0] MODE_ACTIVE = 2'd2;

	// clock input sample codes
	localparam logic [1:0] CLK_ZERO = 2'd0;
	localparam logic [1:0] CLK_POS = 2'd1;

	localparam logic [15:0] PERIOD_RESET = 16'd1024;

	// button and lamp bit positions
	localparam int BTN_DIVIDE = 6;
	localparam int BTN_ACTIVE = 7;
	localparam int BTN_STEP0 = 8;

	typedef logic [STEPS-1:0] row_t;

	typedef struct packed {
		logic en;
		logic [TRACK_W-1:0] track;
		row_t mask;
	} toggle_t;

endpackage

FILE: src/gss_pattern.sv
// gate pattern store: one row of step cells per track, toggled by step buttons
module gss_pattern (
	input logic clk,
	input logic arst_n,
	input gss_pkg::toggle_t toggle,
	output gss_pkg::row_t rows [gss_pkg::TRACKS]
);
	import gss_pkg::*;

	row_t rows_q [TRACKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TRACKS; t++) begin
				rows_q[t] <= '0;
			end
		end else if (toggle.en && (toggle.track < TRACK_W'(TRACKS))) begin
			rows_q[toggle.track] <= rows_q[toggle.track] ^ toggle.mask;
		end
	end

	always_comb begin
		for (int t = 0; t < TRACKS; t++) begin
			rows[t] = rows_q[t];
		end
	end

endmodule

FILE: src/six_track_gate_step_sequencer_unit.sv
// top level of the six-track, eight-step gate sequencer
// Each input beat is one sample tick carrying the clock level and 16 button levels; each
// accepted beat yields exactly one output beat with the gate and lamp levels after that
// tick. All of a tick's work is one pass of shallow logic from the registered state into
// the gate and lamp registers, which also hold the output beat, so a new beat is taken in
// every cycle, held back only while an output beat waits unread.
// trigger_period may be written whenever no tick is in flight; it takes effect on the next.
module six_track_gate_step_sequencer_unit (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] clock_level,
	input logic [15:0] button_levels,
	output logic out_valid,
	input logic out_ready,
	output logic [gss_pkg::TRACKS-1:0] gate_outputs,
	output logic [15:0] lamp_outputs
);
	import gss_pkg::*;

	logic [15:0] period_q;
	logic [STEP_W-1:0] step_q;
	logic [TRACK_W-1:0] sel_q;
	logic seen_high_q;
	logic [15:0] timer_q;
	logic [1:0] mode_q;
	logic div_held_q;
	logic act_held_q;
	row_t step_held_q;
	logic [TRACKS-1:0] gate_q;
	logic [15:0] lamp_q;
	logic out_valid_q;

	logic accept;
	row_t rows [TRACKS];
	toggle_t toggle;

	logic [STEP_W-1:0] step_n;
	logic [STEP_W-1:0] prev_step;
	logic [TRACK_W-1:0] sel_n;
	logic seen_high_n;
	logic [15:0] timer_n;
	logic [15:0] timer_inc;
	logic [1:0] mode_n;
	logic [TRACKS-1:0] gate_n;
	logic [TRACKS-1:0] column;
	logic [TRACKS-1:0] track_lamps;
	row_t step_lamps;
	row_t row_old;
	row_t row_new;
	row_t step_btn;
	row_t step_rise;
	logic rise;
	logic track_hit;
	logic div_btn;
	logic act_btn;

	assign accept = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign gate_outputs = gate_q;
	assign lamp_outputs = lamp_q;

	gss_pattern u_pattern (
		.clk(clk),
		.arst_n(arst_n),
		.toggle(toggle),
		.rows(rows)
	);

	always_comb begin
		step_btn = button_levels[BTN_STEP0 +: STEPS];
		div_btn = button_levels[BTN_DIVIDE];
		act_btn = button_levels[BTN_ACTIVE];
		track_lamps = lamp_q[TRACKS-1:0];
		step_lamps = lamp_q[BTN_STEP0 +: STEPS];
		gate_n = gate_q;
		step_n = step_q;
		seen_high_n = seen_high_q;
		mode_n = mode_q;
		sel_n = sel_q;
		track_hit = 1'b0;

		if (sel_q < TRACK_W'(TRACKS)) begin
			track_lamps[sel_q] = 1'b1;
			row_old = rows[sel_q];
		end else begin
			row_old = '0;
		end

		// gates load the current column on a clock rise
		for (int t = 0; t < TRACKS; t++) begin
			column[t] = rows[t][step_q];
		end
		prev_step = step_q - 1'b1;
		rise = (clock_level == CLK_POS) && !seen_high_q;
		if (rise) begin
			seen_high_n = 1'b1;
			gate_n = column;
			if (mode_q == MODE_DEFAULT) begin
				step_lamps[prev_step] = row_old[prev_step];
				step_lamps[step_q] = !row_old[step_q];
			end
			step_n = step_q + 1'b1;
		end else if (clock_level == CLK_ZERO) begin
			seen_high_n = 1'b0;
		end

		timer_inc = timer_q + 16'd1;
		timer_n = timer_inc;
		if (timer_inc == period_q) begin
			timer_n = '0;
			gate_n = '0;
		end

		if (div_btn && !div_held_q) begin
			mode_n = (mode_q == MODE_DIVIDE) ? MODE_DEFAULT : MODE_DIVIDE;
		end
		if (act_btn && !act_held_q) begin
			mode_n = MODE_ACTIVE;
		end

		// highest pressed track wins; every track passed over goes dark
		for (int t = 0; t < TRACKS; t++) begin
			if (button_levels[t]) begin
				track_hit = 1'b1;
				sel_n = TRACK_W'(t);
			end
		end
		if (track_hit) begin
			if (sel_q < TRACK_W'(TRACKS)) begin
				track_lamps[sel_q] = 1'b0;
			end
			for (int t = 0; t < TRACKS; t++) begin
				if (button_levels[t] && (TRACK_W'(t) != sel_n)) begin
					track_lamps[t] = 1'b0;
				end
			end
			step_lamps = rows[sel_n];
		end

		step_rise = step_btn & ~step_held_q;
		row_new = (sel_n < TRACK_W'(TRACKS)) ? (rows[sel_n] ^ step_rise) : '0;
		step_lamps = (step_lamps & ~step_rise) | (row_new & step_rise);

		toggle.en = accept && (|step_rise) && (sel_n < TRACK_W'(TRACKS));
		toggle.track = sel_n;
		toggle.mask = step_rise;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_valid) begin
			period_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			sel_q <= '0;
			seen_high_q <= 1'b0;
			timer_q <= '0;
			mode_q <= MODE_DEFAULT;
			div_held_q <= 1'b0;
			act_held_q <= 1'b0;
			step_held_q <= '0;
			gate_q <= '0;
			lamp_q <= '0;
		end else if (accept) begin
			step_q <= step_n;
			sel_q <= sel_n;
			seen_high_q <= seen_high_n;
			timer_q <= timer_n;
			mode_q <= mode_n;
			div_held_q <= div_btn;
			act_held_q <= act_btn;
			step_held_q <= step_btn;
			gate_q <= gate_n;
			lamp_q[TRACKS-1:0] <= track_lamps;
			// mode lamps reflect the mode at the start of the tick
			lamp_q[BTN_DIVIDE] <= (mode_q == MODE_DIVIDE);
			lamp_q[BTN_ACTIVE] <= (mode_q != MODE_DEFAULT) && (mode_q != MODE_DIVIDE);
			lamp_q[BTN_STEP0 +: STEPS] <= step_lamps;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: tb/sv/tb_six_track_gate_step_sequencer_unit.sv
`timescale 1ns / 1ps
// self-checking testbench for the six-track gate step sequencer: directed table, then random ticks
module tb_six_track_gate_step_sequencer_unit;
	import gss_pkg::*;

	localparam logic [1:0] CLK_NEG = 2'd2;
	localparam logic [1:0] CLK_ODD = 2'd3;
	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic [TRACKS-1:0] gates;
		logic [15:0] lamps;
	} panel_t;

	typedef struct packed {
		logic [1:0] lvl;
		logic [15:0] btn;
		logic typed;
		panel_t want;
	} script_row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [1:0] clock_level;
	logic [15:0] button_levels;
	logic out_valid;
	logic out_ready;
	logic [TRACKS-1:0] gate_outputs;
	logic [15:0] lamp_outputs;

	// predicted sequencer state
	row_t seq_rows [TRACKS];
	logic [STEP_W-1:0] seq_step;
	logic [TRACK_W-1:0] seq_track;
	logic seq_clk_high;
	logic [15:0] seq_timer;
	logic [15:0] seq_period;
	logic [1:0] seq_mode;
	logic seq_div_held;
	logic seq_act_held;
	logic [STEPS-1:0] seq_steps_held;
	logic [TRACKS-1:0] seq_gates;
	logic [15:0] seq_lamps;

	panel_t expected_panels [$];
	script_row_t script [$];
	int mismatches;
	int beats_seen;
	int ticks_sent;
	int period_writes;
	int burst_left;
	bit rx_steady;

	// random stimulus generator state: held clock level and held buttons
	logic [1:0] gen_lvl;
	int gen_hold;
	logic [15:0] gen_btn;

	six_track_gate_step_sequencer_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.clock_level(clock_level),
		.button_levels(button_levels),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.gate_outputs(gate_outputs),
		.lamp_outputs(lamp_outputs)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic panel_t advance_sequencer(input logic [1:0] lvl, input logic [15:0] btn);
		logic [STEP_W-1:0] cur;
		logic [STEP_W-1:0] prev;
		logic [TRACKS-1:0] col;
		logic div_now;
		logic act_now;
		int t;
		int s;
		panel_t res;
		seq_lamps[seq_track] = 1'b1;
		case (seq_mode)
			MODE_DEFAULT: begin
				seq_lamps[BTN_DIVIDE] = 1'b0;
				seq_lamps[BTN_ACTIVE] = 1'b0;
			end
			MODE_DIVIDE: begin
				seq_lamps[BTN_DIVIDE] = 1'b1;
				seq_lamps[BTN_ACTIVE] = 1'b0;
			end
			default: begin
				seq_lamps[BTN_DIVIDE] = 1'b0;
				seq_lamps[BTN_ACTIVE] = 1'b1;
			end
		endcase
		if (lvl == CLK_POS && !seq_clk_high) begin
			cur = seq_step;
			seq_clk_high = 1'b1;
			for (t = 0; t < TRACKS; t++)
				col[t] = seq_rows[t][cur];
			seq_gates = col;
			// cursor: previous step shows its cell, current step shows it inverted
			if (seq_mode == MODE_DEFAULT) begin
				prev = cur - 1'b1;
				seq_lamps[BTN_STEP0 + prev] = seq_rows[seq_track][prev];
				seq_lamps[BTN_STEP0 + cur] = ~seq_rows[seq_track][cur];
			end
			seq_step = cur + 1'b1;
		end
		if (lvl == CLK_ZERO)
			seq_clk_high = 1'b0;
		seq_timer = seq_timer + 16'd1;
		if (seq_timer == seq_period) begin
			seq_timer = '0;
			seq_gates = '0;
		end
		div_now = btn[BTN_DIVIDE];
		act_now = btn[BTN_ACTIVE];
		if (div_now && !seq_div_held)
			seq_mode = (seq_mode == MODE_DIVIDE) ? MODE_DEFAULT : MODE_DIVIDE;
		if (act_now && !seq_act_held)
			seq_mode = MODE_ACTIVE;
		seq_div_held = div_now;
		seq_act_held = act_now;
		// highest pressed track wins
		for (t = 0; t < TRACKS; t++) begin
			if (btn[t]) begin
				seq_lamps[seq_track] = 1'b0;
				seq_track = TRACK_W'(t);
				seq_lamps[15:8] = seq_rows[t];
			end
		end
		for (s = 0; s < STEPS; s++) begin
			if (btn[BTN_STEP0 + s] && !seq_steps_held[s]) begin
				seq_rows[seq_track][s] = ~seq_rows[seq_track][s];
				seq_lamps[BTN_STEP0 + s] = seq_rows[seq_track][s];
			end
		end
		seq_steps_held = btn[15:8];
		res.gates = seq_gates;
		res.lamps = seq_lamps;
		return res;
	endfunction

	function automatic void add_row(input logic [1:0] lvl, input logic [15:0] btn,
			input logic typed, input logic [TRACKS-1:0] gates, input logic [15:0] lamps);
		script_row_t r;
		r.lvl = lvl;
		r.btn = btn;
		r.typed = typed;
		r.want.gates = gates;
		r.want.lamps = lamps;
		script.push_back(r);
	endfunction

	task automatic send_beat(input logic [1:0] lvl, input logic [15:0] btn, input logic typed,
			input panel_t want);
		panel_t got;
		in_valid <= 1'b1;
		clock_level <= lvl;
		button_levels <= btn;
		do @(posedge clk); while (!in_ready);
		got = advance_sequencer(lvl, btn);
		expected_panels.push_back(typed ? want : got);
		ticks_sent++;
	endtask

	task automatic pause_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// sender quiet until every predicted beat is back
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_panels.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_period(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		seq_period = value;
		period_writes++;
	endtask

	task automatic next_stimulus(output logic [1:0] lvl, output logic [15:0] btn);
		int pick;
		if (gen_hold == 0) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				gen_lvl = CLK_NEG;
			else if (pick == 1)
				gen_lvl = CLK_ODD;
			else
				gen_lvl = (gen_lvl == CLK_POS) ? CLK_ZERO : CLK_POS;
			gen_hold = $urandom_range(0, 3);
		end else begin
			gen_hold--;
		end
		// buttons are held over several ticks so that edges stay rare
		pick = $urandom_range(0, 99);
		if (pick < 13)
			gen_btn = '0;
		else if (pick < 25)
			gen_btn[BTN_STEP0 + $urandom_range(0, STEPS - 1)] = 1'b1;
		else if (pick < 32)
			gen_btn[$urandom_range(0, TRACKS - 1)] = 1'b1;
		else if (pick < 36)
			gen_btn[BTN_DIVIDE] = 1'b1;
		else if (pick < 39)
			gen_btn[BTN_ACTIVE] = 1'b1;
		else if (pick < 42)
			gen_btn[$urandom_range(0, 15)] = 1'b0;
		else if (pick < 45)
			gen_btn = 16'($urandom());
		lvl = gen_lvl;
		btn = gen_btn;
	endtask

	task automatic run_random(input int count, input bit with_gaps);
		logic [1:0] lvl;
		logic [15:0] btn;
		int i;
		for (i = 0; i < count; i++) begin
			if (with_gaps && i == count / 2)
				settle();
			next_stimulus(lvl, btn);
			send_beat(lvl, btn, 1'b0, '0);
			if (with_gaps) begin
				burst_left--;
				if (burst_left <= 0) begin
					pause_sender($urandom_range(1, 6));
					burst_left = $urandom_range(1, 24);
				end
			end
		end
		settle();
	endtask

	task automatic note_mismatch(input string what, input logic [15:0] want, input logic [15:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
	endtask

	always @(posedge clk) begin : beat_check
		panel_t want;
		if (arst_n && out_valid && out_ready) begin
			beats_seen++;
			if (expected_panels.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: beat with nothing expected, actual gates %h lamps %h",
						$time, gate_outputs, lamp_outputs);
			end else begin
				want = expected_panels.pop_front();
				if (gate_outputs !== want.gates)
					note_mismatch("gate_outputs", 16'(want.gates), 16'(gate_outputs));
				if (lamp_outputs !== want.lamps)
					note_mismatch("lamp_outputs", want.lamps, lamp_outputs);
			end
		end
	end

	// receiver: stall pattern is redrawn whenever its countdown runs out, with a long hold-off now and then
	initial begin
		int hold_left;
		int mode;
		int k;
		int cnt;
		int rx_beats;
		int next_hold;
		out_ready = 1'b0;
		hold_left = 0;
		mode = 0;
		k = 2;
		cnt = 0;
		rx_beats = 0;
		next_hold = 300;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				rx_beats++;
			if (cnt == 0) begin
				mode = $urandom_range(0, 2);
				k = $urandom_range(2, 5);
				cnt = 32;
			end
			cnt--;
			if (rx_beats >= next_hold && !rx_steady) begin
				hold_left = 120;
				next_hold = rx_beats + 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_steady || mode == 0) begin
				out_ready <= 1'b1;
			end else if (mode == 1) begin
				out_ready <= 1'($urandom_range(0, 1));
			end else begin
				out_ready <= (cnt % k == 0);
			end
		end
	end

	initial begin
		script_row_t row;
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		clock_level = CLK_ZERO;
		button_levels = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		rx_steady = 1'b0;
		mismatches = 0;
		beats_seen = 0;
		ticks_sent = 0;
		period_writes = 0;
		burst_left = 8;
		gen_lvl = CLK_ZERO;
		gen_hold = 0;
		gen_btn = '0;
		for (i = 0; i < TRACKS; i++)
			seq_rows[i] = '0;
		seq_step = '0;
		seq_track = '0;
		seq_clk_high = 1'b0;
		seq_timer = '0;
		seq_period = PERIOD_RESET;
		seq_mode = MODE_DEFAULT;
		seq_div_held = 1'b0;
		seq_act_held = 1'b0;
		seq_steps_held = '0;
		seq_gates = '0;
		seq_lamps = '0;

		//      level     buttons   typed  gates  lamps
		add_row(CLK_ZERO, 16'h0000, 1'b1, 6'h00, 16'h0001);
		add_row(CLK_POS, 16'h0000, 1'b1, 6'h00, 16'h0101);
		add_row(CLK_ZERO, 16'hFF00, 1'b1, 6'h00, 16'hFF01);
		add_row(CLK_POS, 16'hFF00, 1'b0, '0, '0);
		add_row(CLK_ODD, 16'h0000, 1'b0, '0, '0);
		add_row(CLK_POS, 16'h0000, 1'b0, '0, '0);
		add_row(CLK_NEG, 16'h0020, 1'b0, '0, '0);
		add_row(CLK_ZERO, 16'h0000, 1'b0, '0, '0);
		add_row(CLK_ZERO, 16'h8100, 1'b0, '0, '0);
		add_row(CLK_POS, 16'h0040, 1'b0, '0, '0);
		add_row(CLK_ZERO, 16'h0040, 1'b0, '0, '0);
		add_row(CLK_POS, 16'h0000, 1'b0, '0, '0);
		add_row(CLK_ZERO, 16'h0040, 1'b0, '0, '0);
		add_row(CLK_POS, 16'h0080, 1'b0, '0, '0);
		// divide edge while in active mode, active still held
		add_row(CLK_ZERO, 16'h00C0, 1'b0, '0, '0);
		add_row(CLK_ZERO, 16'hFFFF, 1'b0, '0, '0);
		add_row(CLK_NEG, 16'h0003, 1'b0, '0, '0);
		add_row(CLK_POS, 16'h0000, 1'b0, '0, '0);
		add_row(CLK_ZERO, 16'h0000, 1'b0, '0, '0);
		add_row(CLK_POS, 16'h0000, 1'b0, '0, '0);
		add_row(CLK_ZERO, 16'h0000, 1'b0, '0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < script.size(); i++) begin
			row = script[i];
			send_beat(row.lvl, row.btn, row.typed, row.want);
			if ($urandom_range(0, 3) == 0)
				pause_sender($urandom_range(1, 3));
		end
		settle();

		write_period(16'd1);
		run_random(250, 1'b1);
		write_period(16'd2);
		run_random(200, 1'b1);
		write_period(16'd37);
		run_random(250, 1'b1);
		write_period(16'($urandom_range(3, 400)));
		run_random(250, 1'b1);
		write_period(16'hFFFF);
		run_random(200, 1'b1);
		// period below the running timer: no clear until the timer wraps
		write_period(seq_timer >> 1);
		run_random(200, 1'b1);
		// zero period: gates clear only when the timer wraps to zero
		write_period(16'd0);
		rx_steady = 1'b1;
		run_random(180, 1'b0);
		rx_steady = 1'b0;
		write_period(seq_timer + 16'($urandom_range(20, 150)));
		run_random(200, 1'b1);

		$display("ran %0d ticks, %0d period writes, %0d beats checked, %0d mismatches",
			ticks_sent, period_writes, beats_seen, mismatches);
		$display("included all clock levels, mode edges, track scans and a zero trigger period");
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
src/gss_pkg.sv
src/gss_pattern.sv
src/six_track_gate_step_sequencer_unit.sv
tb/sv/tb_six_track_gate_step_sequencer_unit.sv
